/* hdl/epws_pkg.sv */
// Shared types and constants for the EEPROM page-write splitter.
// No dependencies; used by the other modules under hdl/ except epws_queue.
`default_nettype none
package epws_pkg;

  localparam int unsigned MAX_REQUEST_BYTES = 256;
  localparam int unsigned MAX_RESULTS       = 33;
  localparam int unsigned DIV_STEPS         = 11;   // dividend bits (address bits 10..0)
  localparam int unsigned MIN_PAGE_BYTES    = 8;

  localparam int unsigned RESULT_CNT_W = $clog2(MAX_RESULTS + 1);
  localparam int unsigned DIV_CNT_W    = $clog2(DIV_STEPS);

  // config register indexes
  localparam logic [1:0] REG_BASE_DEVICE_ADDR = 2'd0;
  localparam logic [1:0] REG_PAGE_BYTES       = 2'd1;
  localparam logic [1:0] REG_LAST_VALID_ADDR  = 2'd2;

  typedef struct packed {
    logic [6:0]  base_device_addr;
    logic [7:0]  page_bytes;
    logic [10:0] last_valid_addr;
  } cfg_t;

  // classified request, front -> back
  typedef struct packed {
    logic [15:0] start_addr;
    logic [8:0]  byte_count;   // already saturated
    logic [7:0]  page_ofs;     // start_addr[10:0] mod page_bytes
  } req_t;

  typedef struct packed {
    logic [6:0] device_addr;
    logic [7:0] word_addr;
    logic [7:0] chunk_len;
    logic [8:0] data_offset;
    logic       addr_error;
    logic       last_of_run;
  } result_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_RUN
  } back_state_t;

endpackage
`default_nettype wire

/* hdl/epws_front.sv */
// Front end: takes a request beat, saturates the count and finds the page
// offset of the start address with a bit-serial remainder. Uses epws_pkg.
`default_nettype none
module epws_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire logic [15:0]   start_addr,
  input  wire logic [8:0]    byte_count,
  input  wire logic [7:0]    page_bytes,
  output logic               q_push,
  output epws_pkg::req_t     q_data,
  input  wire logic          q_full
);
  import epws_pkg::*;

  front_state_t state, state_next;

  logic [15:0]          start_reg;
  logic [8:0]           count_reg;
  logic [10:0]          dvd;
  logic [7:0]           rem;
  logic [DIV_CNT_W-1:0] step;
  logic [8:0]           sh;
  logic [7:0]           rem_next;
  logic                 accept;

  assign accept = push && !full;

  // one restoring step per cycle; rem < page_bytes keeps sh below 2*page
  always_comb begin
    sh = {rem, dvd[DIV_STEPS-1]};
    if (sh >= {1'b0, page_bytes}) begin
      rem_next = 8'(sh - {1'b0, page_bytes});
    end else begin
      rem_next = sh[7:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (push) state_next = F_DIV;
      F_DIV:  if (step == DIV_CNT_W'(DIV_STEPS - 1)) state_next = F_PUSH;
      F_PUSH: if (!q_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    full   = (state != F_IDLE);
    q_push = (state == F_PUSH) && !q_full;
    q_data.start_addr = start_reg;
    q_data.byte_count = count_reg;
    q_data.page_ofs   = rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      start_reg <= start_addr;
      count_reg <= (byte_count > 9'(MAX_REQUEST_BYTES)) ? 9'(MAX_REQUEST_BYTES) : byte_count;
      dvd       <= start_addr[DIV_STEPS-1:0];
      rem       <= '0;
      step      <= '0;
    end else if (state == F_DIV) begin
      dvd  <= {dvd[DIV_STEPS-2:0], 1'b0};
      rem  <= rem_next;
      step <= step + 1'b1;
    end
  end

endmodule
`default_nettype wire

/* hdl/epws_queue.sv */
// Small register FIFO between front and back ends.
// Generic width and depth; no package dependency.
`default_nettype none
module epws_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  q_full,
  input  wire logic             rd,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  q_empty
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;

  assign q_full  = (fill == CNT_W'(DEPTH));
  assign q_empty = (fill == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        fill <= fill + 1'b1;
      end else if (rd && !wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

/* hdl/epws_back.sv */
// Back end: walks one classified request chunk by chunk into the result
// register, one result beat per cycle while the result register is free. Uses epws_pkg.
`default_nettype none
module epws_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire epws_pkg::cfg_t cfg,
  input  wire epws_pkg::req_t q_data,
  input  wire logic           q_empty,
  output logic                q_pop,
  output logic                res_valid,
  output epws_pkg::result_t   res,
  input  wire logic           res_take
);
  import epws_pkg::*;

  back_state_t state, state_next;

  logic [15:0]             cur;
  logic [8:0]              count;
  logic [8:0]              done;
  logic [7:0]              pofs;
  logic [RESULT_CNT_W-1:0] n;

  logic       slot_free, emit, stop;
  result_t    res_next;
  logic       err, clipped, final_chunk, budget_end;
  logic [7:0] left, chunk0, chunk;
  logic [8:0] remain;
  logic [11:0] end_addr;

  assign slot_free = !res_valid || res_take;

  // chunk arithmetic for the current address
  always_comb begin
    err      = (cur > {5'b0, cfg.last_valid_addr});
    left     = cfg.page_bytes - pofs;
    remain   = count - done;
    chunk0   = (remain > {1'b0, left}) ? left : remain[7:0];
    end_addr = {1'b0, cur[10:0]} + {4'b0, chunk0} - 12'd1;
    clipped  = (end_addr > {1'b0, cfg.last_valid_addr});
    chunk    = clipped ? 8'(cfg.last_valid_addr - cur[10:0] + 11'd1) : chunk0;
    final_chunk = ({1'b0, chunk} == remain);
    budget_end  = (n == RESULT_CNT_W'(MAX_RESULTS - 1));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (!q_empty) state_next = B_RUN;
      B_RUN:  if (emit && stop) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state == B_IDLE) && !q_empty;
    emit  = (state == B_RUN) && slot_free;
    res_next.device_addr = cfg.base_device_addr | {4'b0, cur[10:8]};
    res_next.word_addr   = cur[7:0];
    res_next.data_offset = done;
    if (count == '0) begin
      // empty request: one success beat, no address check
      res_next.chunk_len   = '0;
      res_next.addr_error  = 1'b0;
      res_next.last_of_run = 1'b1;
      stop = 1'b1;
    end else if (err) begin
      res_next.chunk_len   = '0;
      res_next.addr_error  = 1'b1;
      res_next.last_of_run = 1'b1;
      stop = 1'b1;
    end else begin
      res_next.chunk_len = chunk;
      if (final_chunk) begin
        res_next.addr_error  = 1'b0;
        res_next.last_of_run = 1'b1;
      end else if (clipped && budget_end) begin
        // no room left for a separate error beat
        res_next.addr_error  = 1'b1;
        res_next.last_of_run = 1'b1;
      end else begin
        res_next.addr_error  = 1'b0;
        res_next.last_of_run = 1'b0;
      end
      stop = final_chunk || budget_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        res_valid <= 1'b1;
      end else if (res_take) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur   <= q_data.start_addr;
      count <= q_data.byte_count;
      pofs  <= q_data.page_ofs;
      done  <= '0;
      n     <= '0;
    end else if (emit) begin
      cur  <= cur + {8'b0, chunk};
      done <= done + {1'b0, chunk};
      pofs <= '0;   // next chunk starts on a page edge or the run ends
      n    <= n + 1'b1;
    end
    if (emit) begin
      res <= res_next;
    end
  end

endmodule
`default_nettype wire

/* hdl/eeprom_page_write_splitter.sv */
// Path to the first result beat: the page-offset remainder, the queue push, the back-end
//   load and the result register.
// Throughput: the front takes no new request until the last one is pushed to the queue;
//   the back end walks one chunk per cycle while the result register is free.
// Reset: rst (sync, active high) empties the queue, drops any request and
//   restores base 80, page 8 bytes, last valid address 2047.
`default_nettype none
module eeprom_page_write_splitter #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request side
  input  wire logic        push,
  output logic             full,
  input  wire logic [15:0] start_addr,
  input  wire logic [8:0]  byte_count,
  // result side
  output logic             empty,
  input  wire logic        pop,
  output logic [6:0]       device_addr,
  output logic [7:0]       word_addr,
  output logic [7:0]       chunk_len,
  output logic [8:0]       data_offset,
  output logic             addr_error,
  output logic             last_of_run,
  // config write port
  input  wire logic        wr_en,
  input  wire logic [1:0]  wr_index,
  input  wire logic [10:0] wr_data
);
  import epws_pkg::*;

  cfg_t    cfg;
  req_t    fq_data, qb_data;
  result_t res;
  logic    fq_push, q_full, q_empty, q_pop, res_valid, res_take;

  // config registers; page size below the minimum saturates up
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_device_addr <= 7'd80;
      cfg.page_bytes       <= 8'(MIN_PAGE_BYTES);
      cfg.last_valid_addr  <= 11'd2047;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_BASE_DEVICE_ADDR: cfg.base_device_addr <= wr_data[6:0];
        REG_PAGE_BYTES:
          cfg.page_bytes <= (wr_data[7:0] < 8'(MIN_PAGE_BYTES)) ?
                            8'(MIN_PAGE_BYTES) : wr_data[7:0];
        REG_LAST_VALID_ADDR:  cfg.last_valid_addr <= wr_data;
        default: ;
      endcase
    end
  end

  // front: accept and classify (page offset of start address)
  epws_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .start_addr (start_addr),
    .byte_count (byte_count),
    .page_bytes (cfg.page_bytes),
    .q_push     (fq_push),
    .q_data     (fq_data),
    .q_full     (q_full)
  );

  // decoupling queue of classified requests
  epws_queue #(
    .WIDTH ($bits(req_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (fq_push),
    .wr_data (fq_data),
    .q_full  (q_full),
    .rd      (q_pop),
    .rd_data (qb_data),
    .q_empty (q_empty)
  );

  // back: chunk walk into the result register
  epws_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_data    (qb_data),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  assign empty       = !res_valid;
  assign res_take    = pop && res_valid;
  assign device_addr = res.device_addr;
  assign word_addr   = res.word_addr;
  assign chunk_len   = res.chunk_len;
  assign data_offset = res.data_offset;
  assign addr_error  = res.addr_error;
  assign last_of_run = res.last_of_run;

endmodule
`default_nettype wire

/* tb/sv/eeprom_page_write_splitter_tb.sv */
// Self-checking testbench for eeprom_page_write_splitter: directed and random write requests,
// predicted page chunks compared beat by beat against the result queue.
// Depends on epws_pkg (result_t, register indexes, limits) and the RTL under hdl/.
`timescale 1ns / 1ps

module eeprom_page_write_splitter_tb;
  import epws_pkg::*;

  localparam int unsigned IDLE_PCT       = 23;    // chance of an idle cycle on either side
  localparam int unsigned SETTLE_CYCLES  = 40;    // covers the first-beat latency
  localparam int unsigned WATCHDOG_LIMIT = 1000;  // cycles with no beat on either side

  typedef struct packed {
    logic [15:0] start;
    logic [8:0]  count;
  } request_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [15:0] start_addr = '0;
  logic [8:0]  byte_count = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [6:0]  device_addr;
  logic [7:0]  word_addr;
  logic [7:0]  chunk_len;
  logic [8:0]  data_offset;
  logic        addr_error;
  logic        last_of_run;
  logic        wr_en = 1'b0;
  logic [1:0]  wr_index = REG_BASE_DEVICE_ADDR;
  logic [10:0] wr_data = '0;

  // Shadow of the register file, as the block holds it after reset.
  logic [6:0]  cfg_base = 7'd80;
  logic [7:0]  cfg_page = 8'd8;
  logic [10:0] cfg_last = 11'd2047;

  request_t    pending_requests[$];  // requests not yet taken by the block
  result_t     pending_chunks[$];    // chunks predicted but not yet popped

  bit          hold_sender = 1'b0;   // sender stops offering requests
  bit          steady = 1'b0;        // no random idling on either side
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;

  eeprom_page_write_splitter dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .start_addr  (start_addr),
    .byte_count  (byte_count),
    .empty       (empty),
    .pop         (pop),
    .device_addr (device_addr),
    .word_addr   (word_addr),
    .chunk_len   (chunk_len),
    .data_offset (data_offset),
    .addr_error  (addr_error),
    .last_of_run (last_of_run),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // One chunk as the block reports it; device address takes address bits 10..8.
  function automatic result_t make_chunk(input int unsigned addr, input int unsigned len,
                                         input int unsigned offset, input bit err,
                                         input bit last);
    result_t c;
    c.device_addr = cfg_base | {4'b0, addr[10:8]};
    c.word_addr   = addr[7:0];
    c.chunk_len   = len[7:0];
    c.data_offset = offset[8:0];
    c.addr_error  = err;
    c.last_of_run = last;
    return c;
  endfunction

  // Walks one request page by page and queues every chunk it should produce.
  function automatic void split_request(input logic [15:0] start, input logic [8:0] count_in);
    int unsigned total, done, cur, room, len, n;
    bit          clipped, busy;
    total = (count_in > MAX_REQUEST_BYTES) ? MAX_REQUEST_BYTES : count_in;
    if (total == 0) begin
      // empty request: one marker beat, no address check
      pending_chunks.push_back(make_chunk(start, 0, 0, 1'b0, 1'b1));
      return;
    end
    done = 0;
    n    = 0;
    busy = 1'b1;
    while (busy) begin
      cur = (start + done) & 16'hFFFF;
      if (cur > cfg_last) begin
        // walked off the device: error beat ends the run
        pending_chunks.push_back(make_chunk(cur, 0, done, 1'b1, 1'b1));
        break;
      end
      room = cfg_page - (cur % cfg_page);
      len  = total - done;
      if (len > room) len = room;
      clipped = 1'b0;
      if (cur + len - 1 > cfg_last) begin
        len     = cfg_last - cur + 1;
        clipped = 1'b1;
      end
      if (done + len >= total) begin
        pending_chunks.push_back(make_chunk(cur, len, done, 1'b0, 1'b1));
        busy = 1'b0;
      end else if (clipped && n == MAX_RESULTS - 1) begin
        // out of result slots: the clipped chunk carries the error itself
        pending_chunks.push_back(make_chunk(cur, len, done, 1'b1, 1'b1));
        busy = 1'b0;
      end else begin
        pending_chunks.push_back(make_chunk(cur, len, done, 1'b0, 1'b0));
      end
      n++;
      done = (done + len) & 9'h1FF;
      if (n >= MAX_RESULTS) busy = 1'b0;
    end
  endfunction

  // Request driver: predicts on every accepted beat, then offers the next queued request
  // unless idling or held off.
  always @(posedge clk) begin : request_driver
    request_t taken;
    bit       offer;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        taken = pending_requests.pop_front();
        split_request(taken.start, taken.count);
      end
      offer = pending_requests.size() != 0 && !hold_sender &&
              (steady || $urandom_range(99) >= IDLE_PCT);
      if (offer) begin
        push       <= 1'b1;
        start_addr <= pending_requests[0].start;
        byte_count <= pending_requests[0].count;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Result monitor: every popped beat is matched against the oldest predicted chunk.
  always @(posedge clk) begin : result_monitor
    result_t got, want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        got = {device_addr, word_addr, chunk_len, data_offset, addr_error, last_of_run};
        if (pending_chunks.size() == 0) begin
          flag_mismatch("unexpected result beat", 32'(got), 0);
        end else begin
          want = pending_chunks.pop_front();
          if (got.device_addr != want.device_addr)
            flag_mismatch("device_addr", got.device_addr, want.device_addr);
          if (got.word_addr != want.word_addr)
            flag_mismatch("word_addr", got.word_addr, want.word_addr);
          if (got.chunk_len != want.chunk_len)
            flag_mismatch("chunk_len", got.chunk_len, want.chunk_len);
          if (got.data_offset != want.data_offset)
            flag_mismatch("data_offset", got.data_offset, want.data_offset);
          if (got.addr_error != want.addr_error)
            flag_mismatch("addr_error", got.addr_error, want.addr_error);
          if (got.last_of_run != want.last_of_run)
            flag_mismatch("last_of_run", got.last_of_run, want.last_of_run);
        end
      end
      pop <= steady || $urandom_range(99) >= IDLE_PCT;
    end
  end

  // Watchdog: ends the run when neither side moves a beat for too long.
  always @(posedge clk) begin : watchdog
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Register write; the shadow follows at once since writes only happen while idle.
  task automatic write_reg(input logic [1:0] index, input logic [10:0] data);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= index;
    wr_data  <= data;
    case (index)
      REG_BASE_DEVICE_ADDR: cfg_base = data[6:0];
      REG_PAGE_BYTES:       cfg_page = (data[7:0] < MIN_PAGE_BYTES) ? 8'(MIN_PAGE_BYTES)
                                                                    : data[7:0];
      REG_LAST_VALID_ADDR:  cfg_last = data;
      default: ;
    endcase
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic queue_request(input logic [15:0] start, input logic [8:0] count);
    request_t req;
    req.start = start;
    req.count = count;
    pending_requests.push_back(req);
  endtask

  // Mostly requests that land inside the device, a share near its top end to hit
  // clipping and the error beat, and some fully random addresses.
  task automatic queue_random_requests(input int unsigned n);
    int unsigned pick, span;
    logic [15:0] start;
    logic [8:0]  count;
    repeat (n) begin
      pick = $urandom_range(99);
      span = (cfg_last < 40) ? cfg_last : 40;
      if (pick < 65)      start = 16'($urandom_range(cfg_last));
      else if (pick < 85) start = 16'(cfg_last - $urandom_range(span));
      else                start = 16'($urandom);
      pick = $urandom_range(99);
      if (pick < 8)       count = 9'd0;
      else if (pick < 45) count = 9'($urandom_range(24, 1));
      else if (pick < 90) count = 9'($urandom_range(256, 25));
      else                count = 9'($urandom_range(511, 257));
      queue_request(start, count);
    end
  endtask

  // Waits until every request is taken and every chunk popped, then lets the
  // back end settle so a stray extra beat still gets caught.
  task automatic drain();
    while (pending_requests.size() != 0 || pending_chunks.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: base 80, 8-byte pages, 2 KiB device.
    queue_request(16'h0000, 9'd0);      // empty request
    queue_request(16'hFFFF, 9'd0);      // empty request, no address check
    queue_request(16'h8000, 9'd0);
    queue_request(16'h0000, 9'd1);
    queue_request(16'h0000, 9'd256);    // 32 full pages
    queue_request(16'h0000, 9'd511);    // oversized count saturates
    queue_request(16'h0007, 9'd2);      // crosses a page
    queue_request(16'h0001, 9'd256);    // 33 chunks, the most a request gives
    queue_request(16'h0100, 9'd9);
    queue_request(16'h07FF, 9'd1);      // last byte of the device
    queue_request(16'h07FE, 9'd5);      // runs off the end: error beat after the last page
    queue_request(16'h0800, 9'd3);      // first address already invalid
    queue_request(16'hFFFF, 9'd3);
    queue_request(16'h07F8, 9'd300);
    drain();
    queue_random_requests(50);
    drain();

    // Base written with spare high bits, page below the floor, device end mid-page
    // so a clipped chunk can be the 33rd beat with bytes still left.
    write_reg(REG_BASE_DEVICE_ADDR, 11'h7FF);
    write_reg(REG_PAGE_BYTES, 11'd3);
    write_reg(REG_LAST_VALID_ADDR, 11'd258);
    @(negedge clk);
    queue_request(16'h0007, 9'd256);    // result budget runs out before the request is done
    queue_request(16'h0000, 9'd256);
    queue_request(16'h00FA, 9'd20);     // clip then error beat
    queue_request(16'h0100, 9'd3);
    queue_request(16'h0102, 9'd1);
    queue_request(16'h0103, 9'd1);
    drain();
    queue_random_requests(40);
    drain();

    // Largest page, zero base; no idling, and the sender holds off once mid-stream.
    write_reg(REG_BASE_DEVICE_ADDR, 11'd0);
    write_reg(REG_PAGE_BYTES, 11'd255);
    write_reg(REG_LAST_VALID_ADDR, 11'd2047);
    @(negedge clk);
    steady = 1'b1;
    queue_random_requests(30);
    while (pending_requests.size() > 15) @(negedge clk);
    hold_sender = 1'b1;
    while (pending_chunks.size() != 0) @(negedge clk);
    hold_sender = 1'b0;
    queue_random_requests(30);
    drain();
    steady = 1'b0;

    // Random settings; write data spans all 11 bits on every register.
    repeat (3) begin
      write_reg(REG_BASE_DEVICE_ADDR, 11'($urandom_range(2047)));
      write_reg(REG_PAGE_BYTES, 11'($urandom_range(2047)));
      write_reg(REG_LAST_VALID_ADDR, 11'($urandom_range(2047)));
      @(negedge clk);
      queue_random_requests(40);
      drain();
    end

    // One-byte device at address zero, page written as zero.
    write_reg(REG_BASE_DEVICE_ADDR, 11'h055);
    write_reg(REG_PAGE_BYTES, 11'd0);
    write_reg(REG_LAST_VALID_ADDR, 11'd0);
    @(negedge clk);
    queue_request(16'h0000, 9'd1);
    queue_request(16'h0000, 9'd2);      // one byte, then the error beat
    queue_request(16'h0001, 9'd256);
    queue_random_requests(20);
    drain();

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
